// ----- design/automatic_door_controller_defines.svh -----
// ----------------------------------------------------------------------------
// Automatic door controller: assertion macros
// Shared concurrent assertion forms, clocked on clk and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef AUTOMATIC_DOOR_CONTROLLER_DEFINES_SVH
`define AUTOMATIC_DOOR_CONTROLLER_DEFINES_SVH

// Same-cycle implication
`define ADC_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("door controller assertion failed");

// Next-cycle implication
`define ADC_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("door controller assertion failed");

`endif

// ----- design/adc_pkg.sv -----
// ----------------------------------------------------------------------------
// Automatic door controller package
// Door states, request and register codes, configuration and result types.
// ----------------------------------------------------------------------------
package adc_pkg;

  typedef enum logic [2:0] {
    ST_CLOSED    = 3'd0,
    ST_OPENING   = 3'd1,
    ST_OPEN      = 3'd2,
    ST_CLOSING   = 3'd3,
    ST_EMERGENCY = 3'd4
  } door_state_t;

  typedef enum logic [1:0] {
    REQ_UPDATE      = 2'd0,
    REQ_MANUAL_OPEN = 2'd1,
    REQ_EMERG_ON    = 2'd2,
    REQ_EMERG_OFF   = 2'd3
  } req_type_t;

  // Register indexes on the configuration port
  localparam logic [2:0] REG_CLOSED_ANGLE = 3'd0;
  localparam logic [2:0] REG_OPEN_ANGLE   = 3'd1;
  localparam logic [2:0] REG_DIST_THRESH  = 3'd2;
  localparam logic [2:0] REG_OPEN_HOLD    = 3'd3;
  localparam logic [2:0] REG_SERVO_STEP   = 3'd4;

  localparam logic [7:0]  ANGLE_MAX          = 8'd180;
  localparam logic [7:0]  CLOSED_ANGLE_RESET = 8'd0;
  localparam logic [7:0]  OPEN_ANGLE_RESET   = 8'd90;
  localparam logic [15:0] DIST_THRESH_RESET  = 16'd300;
  localparam logic [31:0] OPEN_HOLD_RESET    = 32'd3000;
  localparam logic [31:0] SERVO_STEP_RESET   = 32'd15;

  typedef struct packed {
    logic [7:0]  closed_angle;
    logic [7:0]  open_angle;
    logic [15:0] dist_thresh;
    logic [31:0] open_hold_ms;
    logic [31:0] servo_step_ms;
  } adc_cfg_t;

  typedef struct packed {
    door_state_t door_state;
    logic [7:0]  angle;
    logic        servo_write;
  } adc_result_t;

  // Keep the low byte and clamp it to the servo range
  function automatic logic [7:0] sat_angle(input logic [31:0] value);
    logic [7:0] low;
    low = value[7:0];
    return (low > ANGLE_MAX) ? ANGLE_MAX : low;
  endfunction

endpackage

// ----- design/automatic_door_controller.sv -----
// ----------------------------------------------------------------------------
// Automatic door controller
// Five-state door machine driving a servo angle, one result per request.
// ----------------------------------------------------------------------------
// Usage:
//   Requests enter on in_valid / in_stall with req_type, now_ms and
//   distance_mm. Every request yields exactly one result on out_valid /
//   out_stall carrying door_state, angle and servo_write.
//   Registers are written on cfg_valid / cfg_ready (cfg_ready is always high)
//   with cfg_index and cfg_data; the user must write them only while no
//   request is in flight, and the block itself does not enforce this.
//   An accepted request is evaluated from the input register into the result
//   register. Throughput: one request per cycle while no result is stalled;
//   state, angle and timestamps update per request, so back-to-back ones chain.
//   Reset: door closed, angle 0, timestamps 0, registers at their defaults,
//   both pipeline stages empty.
//   Stall: a stalled result holds in the output register; the input register
//   still takes one more request, after which in_stall rises.
// ----------------------------------------------------------------------------
`include "automatic_door_controller_defines.svh"

module automatic_door_controller (
  input  logic        clk,
  input  logic        rst,
  // request channel
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  req_type,
  input  logic [31:0] now_ms,
  input  logic [15:0] distance_mm,
  // result channel
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  door_state,
  output logic [7:0]  angle,
  output logic        servo_write,
  // configuration channel
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import adc_pkg::*;

  adc_cfg_t    cfg;
  adc_result_t result;
  adc_result_t out_result;

  logic        s1_valid;
  logic [1:0]  s1_req;
  logic [31:0] s1_now;
  logic [15:0] s1_dist;
  logic        in_fire;
  logic        out_free;
  logic        s1_advance;

  assign cfg_ready  = 1'b1;
  assign out_free   = !out_valid || !out_stall;
  assign s1_advance = s1_valid && out_free;
  assign in_stall   = s1_valid && !out_free;
  assign in_fire    = in_valid && !in_stall;

  // Configuration register file
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.closed_angle  <= CLOSED_ANGLE_RESET;
      cfg.open_angle    <= OPEN_ANGLE_RESET;
      cfg.dist_thresh   <= DIST_THRESH_RESET;
      cfg.open_hold_ms  <= OPEN_HOLD_RESET;
      cfg.servo_step_ms <= SERVO_STEP_RESET;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_CLOSED_ANGLE: cfg.closed_angle  <= sat_angle(cfg_data);
        REG_OPEN_ANGLE:   cfg.open_angle    <= sat_angle(cfg_data);
        REG_DIST_THRESH:  cfg.dist_thresh   <= cfg_data[15:0];
        REG_OPEN_HOLD:    cfg.open_hold_ms  <= cfg_data;
        REG_SERVO_STEP:   cfg.servo_step_ms <= cfg_data;
        default:          cfg.closed_angle  <= cfg.closed_angle;
      endcase
    end
  end

  // Input register: load on transfer, drain when evaluated
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_advance) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_req  <= req_type;
      s1_now  <= now_ms;
      s1_dist <= distance_mm;
    end
  end

  adc_door_fsm u_fsm (
    .clk         (clk),
    .rst         (rst),
    .advance     (s1_advance),
    .req_type    (req_type_t'(s1_req)),
    .now_ms      (s1_now),
    .distance_mm (s1_dist),
    .cfg         (cfg),
    .result      (result)
  );

  // Result register: load on evaluation, clear after transfer
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_advance) begin
      out_result <= result;
    end
  end

  assign door_state  = out_result.door_state;
  assign angle       = out_result.angle;
  assign servo_write = out_result.servo_write;

  `ADC_ASSERT_NEXT(a_eval_lands, s1_advance, out_valid)
  `ADC_ASSERT_NEXT(a_stall_keeps_result, out_valid && out_stall, out_valid && $stable(out_result))
  `ADC_ASSERT_NOW(a_back_pressure, in_stall, s1_valid && out_valid)

endmodule

// ----- design/adc_door_fsm.sv -----
// ----------------------------------------------------------------------------
// Door state machine
// Holds door state, angle and timestamps; computes the result of one request.
// ----------------------------------------------------------------------------
`include "automatic_door_controller_defines.svh"

module adc_door_fsm (
  input  logic               clk,
  input  logic               rst,
  input  logic               advance,
  input  adc_pkg::req_type_t req_type,
  input  logic [31:0]        now_ms,
  input  logic [15:0]        distance_mm,
  input  adc_pkg::adc_cfg_t  cfg,
  output adc_pkg::adc_result_t result
);
  import adc_pkg::*;

  door_state_t state, state_next;
  logic [7:0]  angle, angle_next;
  logic [31:0] open_start_time, open_start_time_next;
  logic [31:0] last_step_time, last_step_time_next;
  logic        servo_write;

  door_state_t decided;
  logic [7:0]  angle_inc;
  logic        step_due;
  logic        hold_done;
  logic        emerg_hold;
  logic        emerg_clear;

  // Wrapping time differences against their limits
  assign step_due  = (now_ms - last_step_time) >= cfg.servo_step_ms;
  assign hold_done = (now_ms - open_start_time) >= cfg.open_hold_ms;
  assign angle_inc = (angle < ANGLE_MAX) ? angle + 8'd1 : ANGLE_MAX;

  // Hold state registers until a request advances
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_CLOSED;
      angle           <= CLOSED_ANGLE_RESET;
      open_start_time <= '0;
      last_step_time  <= '0;
    end else if (advance) begin
      state           <= state_next;
      angle           <= angle_next;
      open_start_time <= open_start_time_next;
      last_step_time  <= last_step_time_next;
    end
  end

  // Decide the new state, then step the servo on updates; manual and emergency requests act directly
  always_comb begin
    state_next           = state;
    angle_next           = angle;
    open_start_time_next = open_start_time;
    last_step_time_next  = last_step_time;
    servo_write          = 1'b0;
    decided              = state;

    unique case (req_type)
      REQ_UPDATE: begin
        if (state != ST_EMERGENCY) begin
          unique case (state)
            ST_CLOSED: begin
              if (distance_mm != 16'd0 && distance_mm < cfg.dist_thresh) begin
                decided = ST_OPENING;
              end
            end
            ST_OPENING: begin
              if (angle >= cfg.open_angle) begin
                decided              = ST_OPEN;
                open_start_time_next = now_ms;
              end
            end
            ST_OPEN: begin
              if (hold_done) begin
                decided = ST_CLOSING;
              end
            end
            ST_CLOSING: begin
              if (angle <= cfg.closed_angle) begin
                decided = ST_CLOSED;
              end
            end
            default: decided = state;
          endcase
          state_next = decided;

          if (step_due) begin
            last_step_time_next = now_ms;
            if (decided == ST_OPENING && angle < cfg.open_angle) begin
              angle_next  = angle_inc;
              servo_write = 1'b1;
            end else if (decided == ST_CLOSING && angle > cfg.closed_angle) begin
              angle_next  = angle - 8'd1;
              servo_write = 1'b1;
            end
          end
        end
      end
      REQ_MANUAL_OPEN: begin
        if (state == ST_CLOSED) begin
          state_next = ST_OPENING;
        end else if (state == ST_CLOSING) begin
          state_next = ST_OPENING;
          angle_next = angle_inc;
        end
      end
      REQ_EMERG_ON: begin
        state_next = ST_EMERGENCY;
      end
      REQ_EMERG_OFF: begin
        state_next  = ST_CLOSED;
        angle_next  = cfg.closed_angle;
        servo_write = 1'b1;
      end
      default: state_next = state;
    endcase
  end

  assign result.door_state  = state_next;
  assign result.angle       = angle_next;
  assign result.servo_write = servo_write;

  // Requests that keep or clear an emergency
  assign emerg_hold  = advance && state == ST_EMERGENCY && req_type != REQ_EMERG_OFF;
  assign emerg_clear = advance && req_type == REQ_EMERG_OFF;

  `ADC_ASSERT_NOW(a_angle_in_range, 1'b1, angle <= ANGLE_MAX)
  `ADC_ASSERT_NEXT(a_emerg_frozen, emerg_hold, state == ST_EMERGENCY && $stable(angle))
  `ADC_ASSERT_NEXT(a_emerg_off_closes, emerg_clear, state == ST_CLOSED && angle == $past(cfg.closed_angle))
  `ADC_ASSERT_NOW(a_write_moves_or_clears, servo_write && req_type == REQ_UPDATE, angle_next != angle)

endmodule
